// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL. Defining NO_ASSERTIONS removes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/bmrf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bmrf_pkg;

    // Default sizing of the bitmap.
    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int MAX_HEIGHT_DEF  = 2048;
    localparam int PITCH_ALIGN_DEF = 32;

    // Field and register widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int FW_W       = 12;
    localparam int FH_W       = 12;
    localparam int OFF_W      = 10;
    localparam int SX_W       = 11;
    localparam int SY_W       = 11;
    localparam int RW_W       = 12;
    localparam int RH_W       = 12;
    localparam int BADDR_W    = 19;
    localparam int RDATA_W    = 8;

    // Widths of the walk. Start plus offset stays below 4096, the exclusive end
    // column below 8192 and the line index below 8192.
    localparam int X_W       = 12;
    localparam int HI_W      = 13;
    localparam int FIRST_W   = X_W - 3;
    localparam int BCOL_W    = HI_W - 3;
    localparam int ROWY_W    = 13;
    localparam int BYTES_W   = FW_W - 3;
    localparam int BYTES_MAX = (1 << BYTES_W) - 1;

    // Register reset values.
    localparam logic [FW_W-1:0]  FW_RST = 12'd1920;
    localparam logic [FH_W-1:0]  FH_RST = 12'd1080;
    localparam logic [OFF_W-1:0] XO_RST = 10'd0;
    localparam logic [OFF_W-1:0] YO_RST = 10'd0;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_X_OFFSET     = 2'd2,
        CFG_Y_OFFSET     = 2'd3
    } t_cfg_index;

    // Command and status codes.
    localparam logic CMD_FILL      = 1'b0;
    localparam logic CMD_READ      = 1'b1;
    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic               command;
        logic [SX_W-1:0]    start_x;
        logic [SY_W-1:0]    start_y;
        logic [RW_W-1:0]    rect_width;
        logic [RH_W-1:0]    rect_height;
        logic               remove;
        logic [BADDR_W-1:0] byte_address;
    } t_in_word;

    typedef struct packed {
        logic               status;
        logic [RDATA_W-1:0] read_data;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_MOD,
        ST_RD_MEM,
        ST_RD_DATA,
        ST_PITCH,
        ST_ROW_MUL,
        ST_ROW_ADD,
        ST_ROW_MOD,
        ST_BYTE_RD,
        ST_BYTE_WR,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/bmrf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Generic RAM: one write port, one read port, registered read data.
module bmrf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/bmrf_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Remainder by a constant divisor through reciprocal multiplication. The
// quotient is the value times a scaled reciprocal, shifted down. The reciprocal
// is rounded up, and the shift is chosen so that the quotient is exact for every
// VALUE_W-bit value. Both products are by constants. The value is taken on
// i_start, and the quotient is registered in the cycle after. The remainder is
// registered in the cycle after that, when o_done pulses for one cycle. o_rem
// holds until the next start.
module bmrf_mod #(
    parameter int VALUE_W = 24,
    parameter int DIVISOR = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_done,
    output logic      [VALUE_W-1:0] o_rem
);

    localparam int DW     = $clog2(DIVISOR);
    localparam int SHIFT  = VALUE_W + DW;
    localparam int MW     = VALUE_W + 2;
    localparam int PROD_W = VALUE_W + MW;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0]      RECIP = MW'(RECIP_L);
    localparam logic [VALUE_W-1:0] DIV_V = VALUE_W'(DIVISOR);

    logic               r_stage1;
    logic               r_stage2;
    logic               r_done;
    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] r_quo;
    logic [VALUE_W-1:0] r_rem;
    logic [PROD_W-1:0]  w_prod;
    logic [VALUE_W-1:0] w_quo;
    logic [VALUE_W-1:0] w_back;

    // Quotient from the scaled reciprocal, and the quotient times the divisor.
    assign w_prod = PROD_W'(r_val) * PROD_W'(RECIP);
    assign w_quo  = VALUE_W'(w_prod >> SHIFT);
    assign w_back = r_quo * DIV_V;

    // Stage flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage1 <= 1'b0;
            r_stage2 <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_stage1 <= i_start;
            r_stage2 <= r_stage1;
            r_done   <= r_stage2;
        end
    end

    // Value, quotient and remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end
        if (r_stage1) begin
            r_quo <= w_quo;
        end
        if (r_stage2) begin
            r_rem <= r_val - w_back;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- rtl/bitmap_rectangle_fill.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One-bit-per-pixel rectangle fill over a byte-packed mask bitmap held in a
// block RAM of (MAX_WIDTH/8)*MAX_HEIGHT bytes.
// Input words come in on i_valid/o_stall, one result word per command goes
// out on o_valid/i_stall. Registers are written through i_cfg_we, i_cfg_index
// and i_cfg_data at any edge; they are meant to change only while idle.
// After reset a clearing pass writes zero to every byte, one byte a cycle;
// o_stall stays high meanwhile.
// One command is worked at a time, and o_stall drops when its result enters
// the output register. A read wraps the byte address, reads the RAM and
// registers the byte before posting it; a rejected fill posts its result
// directly. An accepted fill computes the pitch, then per line forms the line
// address and does a read-modify-write of each byte through the single RAM
// port pair, and then posts the result.
// The result sits in an output register; while the receiver stalls it holds,
// and the block may take the next command, whose result waits until the
// register is free.
module bitmap_rectangle_fill
    import bmrf_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int PITCH_ALIGN = PITCH_ALIGN_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_in_word              i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_out_word                  o_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int unsigned BB = (MAX_WIDTH / 8) * MAX_HEIGHT;
    localparam int AW      = $clog2(BB);
    localparam int PW      = $clog2(BYTES_MAX + PITCH_ALIGN);
    localparam int PROD_W  = ROWY_W + PW;
    localparam int RAW_W   = PROD_W + 1;
    localparam int AMOD_W  = (RAW_W > BADDR_W) ? RAW_W : BADDR_W;

    // Configuration registers.
    logic [FW_W-1:0]  r_cfg_fw;
    logic [FH_W-1:0]  r_cfg_fh;
    logic [OFF_W-1:0] r_cfg_xo;
    logic [OFF_W-1:0] r_cfg_yo;

    // Sequencer state.
    t_state              r_state, n_state;
    logic [AW-1:0]       r_caddr, n_caddr;
    logic                r_clear, n_clear;
    logic [ROWY_W-1:0]   r_row_y, n_row_y;
    logic [RH_W-1:0]     r_rows, n_rows;
    logic [FIRST_W-1:0]  r_first, n_first;
    logic [BCOL_W-1:0]   r_last, n_last;
    logic [2:0]          r_lo, n_lo;
    logic [3:0]          r_hi_e, n_hi_e;
    logic [PW-1:0]       r_pitch, n_pitch;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [AW-1:0]       r_addr, n_addr;
    logic [BCOL_W-1:0]   r_bcol, n_bcol;
    t_out_word           r_res, n_res;
    t_out_word           r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // Datapath signals.
    logic                w_accept;
    logic                w_reject;
    logic [X_W-1:0]      w_x;
    logic [X_W-1:0]      w_y;
    logic [HI_W-1:0]     w_hi_m1;
    logic                w_pmod_start;
    logic                w_pmod_done;
    logic [BYTES_W-1:0]  w_prem;
    logic [PW-1:0]       w_pitch_calc;
    logic                w_amod_start;
    logic [AMOD_W-1:0]   w_amod_value;
    logic                w_amod_done;
    logic [AMOD_W-1:0]   w_arem;
    logic                w_mem_we;
    logic [AW-1:0]       w_mem_waddr;
    logic [RDATA_W-1:0]  w_mem_wdata;
    logic [RDATA_W-1:0]  w_mem_rdata;
    logic [2:0]          w_s;
    logic [3:0]          w_e;
    logic [RDATA_W-1:0]  w_mask;
    logic [RDATA_W-1:0]  w_modified;
    logic [AW-1:0]       w_addr_inc;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_fw <= FW_RST;
            r_cfg_fh <= FH_RST;
            r_cfg_xo <= XO_RST;
            r_cfg_yo <= YO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_cfg_fw <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_cfg_fh <= i_cfg_data[FH_W-1:0];
                CFG_X_OFFSET:     r_cfg_xo <= i_cfg_data[OFF_W-1:0];
                CFG_Y_OFFSET:     r_cfg_yo <= i_cfg_data[OFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Frame check and rectangle geometry of the incoming word.
    assign w_accept = i_valid && !o_stall;
    assign w_reject = (i_data.rect_width == '0) || (i_data.rect_height == '0)
        || (({2'b00, i_data.start_x} + {1'b0, i_data.rect_width}) > {1'b0, r_cfg_fw})
        || (({2'b00, i_data.start_y} + {1'b0, i_data.rect_height}) > {1'b0, r_cfg_fh});
    assign w_x     = {1'b0, i_data.start_x} + {2'b00, r_cfg_xo};
    assign w_y     = {1'b0, i_data.start_y} + {2'b00, r_cfg_yo};
    assign w_hi_m1 = {1'b0, w_x} + {1'b0, i_data.rect_width} - 13'd1;

    // Pitch: bytes per line rounded up to the alignment.
    bmrf_mod #(
        .VALUE_W (BYTES_W),
        .DIVISOR (PITCH_ALIGN)
    ) u_pitch_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_pmod_start),
        .i_value (r_cfg_fw[FW_W-1:3]),
        .o_done  (w_pmod_done),
        .o_rem   (w_prem)
    );

    assign w_pitch_calc = (w_prem == '0) ? PW'(r_cfg_fw[FW_W-1:3])
        : PW'(r_cfg_fw[FW_W-1:3]) + PW'(PITCH_ALIGN) - PW'(w_prem);

    // Bitmap address wrap, shared by reads and line starts.
    bmrf_mod #(
        .VALUE_W (AMOD_W),
        .DIVISOR (BB)
    ) u_addr_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_amod_start),
        .i_value (w_amod_value),
        .o_done  (w_amod_done),
        .o_rem   (w_arem)
    );

    // Bitmap storage.
    bmrf_ram #(
        .DATA_W (RDATA_W),
        .DEPTH  (BB)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_mem_rdata)
    );

    // Edge-byte mask and the modified byte.
    assign w_s        = (r_bcol == {1'b0, r_first}) ? r_lo : 3'd0;
    assign w_e        = (r_bcol == r_last) ? r_hi_e : 4'd8;
    assign w_mask     = (8'hFF >> (4'd8 - w_e)) & (8'hFF << w_s);
    assign w_modified = r_clear ? (w_mem_rdata & ~w_mask) : (w_mem_rdata | w_mask);
    assign w_addr_inc = (r_addr == AW'(BB - 1)) ? '0 : r_addr + 1'b1;

    assign w_mem_we    = (r_state == ST_CLEAR) || (r_state == ST_BYTE_WR);
    assign w_mem_waddr = (r_state == ST_CLEAR) ? r_caddr : r_addr;
    assign w_mem_wdata = (r_state == ST_CLEAR) ? '0 : w_modified;

    // Next state and sequencer outputs.
    always_comb begin
        n_state      = r_state;
        n_caddr      = r_caddr;
        n_clear      = r_clear;
        n_row_y      = r_row_y;
        n_rows       = r_rows;
        n_first      = r_first;
        n_last       = r_last;
        n_lo         = r_lo;
        n_hi_e       = r_hi_e;
        n_pitch      = r_pitch;
        n_prod       = r_prod;
        n_addr       = r_addr;
        n_bcol       = r_bcol;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_stall;
        w_pmod_start = 1'b0;
        w_amod_start = 1'b0;
        w_amod_value = AMOD_W'(r_prod) + AMOD_W'(r_first);

        case (r_state)
            ST_CLEAR: begin
                n_caddr = r_caddr + 1'b1;
                if (r_caddr == AW'(BB - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_data.command == CMD_READ) begin
                        w_amod_value = AMOD_W'(i_data.byte_address);
                        w_amod_start = 1'b1;
                        n_state      = ST_RD_MOD;
                    end else if (w_reject) begin
                        n_res.status    = STATUS_REJECT;
                        n_res.read_data = '0;
                        n_state         = ST_DONE;
                    end else begin
                        n_clear      = i_data.remove;
                        n_row_y      = {1'b0, w_y};
                        n_rows       = i_data.rect_height;
                        n_first      = w_x[X_W-1:3];
                        n_last       = w_hi_m1[HI_W-1:3];
                        n_lo         = w_x[2:0];
                        n_hi_e       = {1'b0, w_hi_m1[2:0]} + 4'd1;
                        w_pmod_start = 1'b1;
                        n_state      = ST_PITCH;
                    end
                end
            end
            ST_RD_MOD: begin
                if (w_amod_done) begin
                    n_addr  = w_arem[AW-1:0];
                    n_state = ST_RD_MEM;
                end
            end
            ST_RD_MEM: begin
                n_state = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                n_res.status    = STATUS_DONE;
                n_res.read_data = w_mem_rdata;
                n_state         = ST_DONE;
            end
            ST_PITCH: begin
                if (w_pmod_done) begin
                    n_pitch = w_pitch_calc;
                    n_state = ST_ROW_MUL;
                end
            end
            ST_ROW_MUL: begin
                n_prod  = PROD_W'(r_row_y) * PROD_W'(r_pitch);
                n_state = ST_ROW_ADD;
            end
            ST_ROW_ADD: begin
                w_amod_start = 1'b1;
                n_state      = ST_ROW_MOD;
            end
            ST_ROW_MOD: begin
                if (w_amod_done) begin
                    n_addr  = w_arem[AW-1:0];
                    n_bcol  = {1'b0, r_first};
                    n_state = ST_BYTE_RD;
                end
            end
            ST_BYTE_RD: begin
                n_state = ST_BYTE_WR;
            end
            ST_BYTE_WR: begin
                if (r_bcol == r_last) begin
                    n_rows  = r_rows - 1'b1;
                    n_row_y = r_row_y + 1'b1;
                    if (r_rows == RH_W'(1)) begin
                        n_res.status    = STATUS_DONE;
                        n_res.read_data = '0;
                        n_state         = ST_DONE;
                    end else begin
                        n_state = ST_ROW_MUL;
                    end
                end else begin
                    n_bcol  = r_bcol + 1'b1;
                    n_addr  = w_addr_inc;
                    n_state = ST_BYTE_RD;
                end
            end
            ST_DONE: begin
                if (!(r_out_valid && i_stall)) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_caddr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_caddr     <= n_caddr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_clear <= n_clear;
        r_row_y <= n_row_y;
        r_rows  <= n_rows;
        r_first <= n_first;
        r_last  <= n_last;
        r_lo    <= n_lo;
        r_hi_e  <= n_hi_e;
        r_pitch <= n_pitch;
        r_prod  <= n_prod;
        r_addr  <= n_addr;
        r_bcol  <= n_bcol;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Checks on the sequencer.
    `ASSERT_IMPLIES(a_amod_done_awaited, i_clk, i_rst_n, w_amod_done, (r_state == ST_RD_MOD) || (r_state == ST_ROW_MOD))
    `ASSERT_IMPLIES(a_mem_write_in_range, i_clk, i_rst_n, w_mem_we, w_mem_waddr <= AW'(BB - 1))
    `ASSERT_IMPLIES(a_bcol_within_line, i_clk, i_rst_n, r_state == ST_BYTE_WR, r_bcol <= r_last)
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state != ST_IDLE)

endmodule

`default_nettype wire
